// ===== rtl/sdi_pkg.sv =====
// Shared types and constants for the SD card SPI-mode start-up sequencer.
// No dependencies; imported by every module of the block.
package sdi_pkg;

  // Command indexes issued to the card
  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_SEND_OP    = 6'd1;
  localparam logic [5:0] CMD_IF_COND    = 6'd8;
  localparam logic [5:0] CMD_SET_BLKLEN = 6'd16;
  localparam logic [5:0] CMD_APP_OP     = 6'd41;
  localparam logic [5:0] CMD_READ_OCR   = 6'd58;

  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [31:0] ARG_BLKLEN  = 32'd512;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  R7_VHS      = 8'h01;
  localparam logic [7:0]  R7_PATTERN  = 8'hAA;

  // Card type bits
  localparam logic [3:0] CT_NONE    = 4'h0;
  localparam logic [3:0] CT_MMC     = 4'h1;
  localparam logic [3:0] CT_SD1     = 4'h2;
  localparam logic [3:0] CT_SD2     = 4'h4;
  localparam logic [3:0] CT_BLKADDR = 4'h8;

  // Register map
  localparam int         CFG_AW = 4;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd0;
  localparam logic [1:0] REG_RETRY_WAIT    = 2'd1;
  localparam logic [1:0] REG_POWER_UP_WAIT = 2'd2;

  localparam logic [15:0] RETRY_LIMIT_RST   = 16'd1000;
  localparam logic [15:0] RETRY_WAIT_RST    = 16'd20;
  localparam logic [15:0] POWER_UP_WAIT_RST = 16'd200;

  localparam logic KIND_START    = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_V2LOOP = 4'd3,
    PH_CMD58  = 4'd4,
    PH_PROBE  = 4'd5,
    PH_V1LOOP = 4'd6,
    PH_CMD16  = 4'd7
  } phase_t;

  typedef struct packed {
    logic [15:0] retry_limit;
    logic [15:0] retry_wait;
    logic [15:0] power_up_wait;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] retries_left;
    logic [3:0]  type_found;
    logic [5:0]  loop_command;
    logic        disk_uninitialized;
  } seq_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  drive;
    logic [7:0]  r1;
    logic [31:0] trailing;
  } item_t;

  typedef struct packed {
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic        app_cmd;
    logic [15:0] wait_units;
    logic        dummy_clocks;
    logic        high_speed;
    logic        read_trailing;
    logic        done_res;
    logic [3:0]  card_type;
    logic        not_ready;
  } result_t;

endpackage

// ===== rtl/sdi_cfg.sv =====
// APB-style register file: retry limit, retry wait and power-up wait.
// Depends on sdi_pkg.
module sdi_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sdi_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output sdi_pkg::cfg_t             cfg
);
  import sdi_pkg::*;

  logic [1:0] reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit   <= RETRY_LIMIT_RST;
      cfg.retry_wait    <= RETRY_WAIT_RST;
      cfg.power_up_wait <= POWER_UP_WAIT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RETRY_LIMIT:   cfg.retry_limit   <= pwdata[15:0];
        REG_RETRY_WAIT:    cfg.retry_wait    <= pwdata[15:0];
        REG_POWER_UP_WAIT: cfg.power_up_wait <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RETRY_LIMIT:   prdata = {16'd0, cfg.retry_limit};
      REG_RETRY_WAIT:    prdata = {16'd0, cfg.retry_wait};
      REG_POWER_UP_WAIT: prdata = {16'd0, cfg.power_up_wait};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/sdi_step.sv =====
// Next-step logic of the sequencer: from the current state and one item,
// the next state and the command or final word. Depends on sdi_pkg.
module sdi_step (
  input  sdi_pkg::seq_state_t st,
  input  sdi_pkg::cfg_t       cfg,
  input  sdi_pkg::item_t      item,
  output sdi_pkg::seq_state_t st_next,
  output logic                has_result,
  output sdi_pkg::result_t    res
);
  import sdi_pkg::*;

  logic        fin;
  logic [3:0]  fin_type;
  logic        lstart;
  phase_t      lphase;
  logic [5:0]  lcmd;
  logic        lfail;
  logic [15:0] dec;

  assign dec = st.retries_left - {15'd0, (st.retries_left != 16'd0)};

  always_comb begin
    st_next    = st;
    res        = '0;
    has_result = 1'b0;
    fin        = 1'b0;
    fin_type   = CT_NONE;
    lstart     = 1'b0;
    lphase     = PH_V2LOOP;
    lcmd       = CMD_APP_OP;
    lfail      = 1'b0;

    if (item.kind == KIND_START) begin
      has_result = 1'b1;
      if (item.drive != 8'd0) begin
        st_next.phase = PH_IDLE;
        res.done_res  = 1'b1;
        res.card_type = CT_NONE;
        res.not_ready = 1'b1;
      end else begin
        st_next.phase        = PH_CMD0;
        st_next.type_found   = CT_NONE;
        st_next.retries_left = 16'd0;
        res.cmd_index        = CMD_GO_IDLE;
        res.wait_units       = cfg.power_up_wait;
        res.dummy_clocks     = 1'b1;
      end
    end else begin
      unique case (st.phase)
        PH_CMD0: begin
          if (item.r1 != R1_IDLE) begin
            fin = 1'b1;
          end else begin
            st_next.phase     = PH_CMD8;
            has_result        = 1'b1;
            res.cmd_index     = CMD_IF_COND;
            res.cmd_arg       = ARG_IF_COND;
            res.high_speed    = 1'b1;
            res.read_trailing = 1'b1;
          end
        end
        PH_CMD8: begin
          if (item.r1 == R1_IDLE) begin
            // SDv2: echo of voltage range and check pattern must match
            if (item.trailing[15:8] != R7_VHS || item.trailing[7:0] != R7_PATTERN) begin
              fin = 1'b1;
            end else begin
              lstart = 1'b1;
              lphase = PH_V2LOOP;
              lcmd   = CMD_APP_OP;
            end
          end else begin
            st_next.phase  = PH_PROBE;
            has_result     = 1'b1;
            res.cmd_index  = CMD_APP_OP;
            res.app_cmd    = 1'b1;
            res.high_speed = 1'b1;
          end
        end
        PH_V2LOOP: begin
          if (item.r1 != 8'd0) begin
            lfail = 1'b1;
          end else begin
            st_next.phase     = PH_CMD58;
            has_result        = 1'b1;
            res.cmd_index     = CMD_READ_OCR;
            res.high_speed    = 1'b1;
            res.read_trailing = 1'b1;
          end
        end
        PH_CMD58: begin
          fin = 1'b1;
          if (item.r1 == 8'd0) begin
            // CCS bit of the OCR selects block addressing
            fin_type = item.trailing[30] ? (CT_SD2 | CT_BLKADDR) : CT_SD2;
          end
        end
        PH_PROBE: begin
          lstart = 1'b1;
          lphase = PH_V1LOOP;
          if (item.r1 <= R1_IDLE) begin
            st_next.type_found = CT_SD1;
            lcmd               = CMD_APP_OP;
          end else begin
            st_next.type_found = CT_MMC;
            lcmd               = CMD_SEND_OP;
          end
        end
        PH_V1LOOP: begin
          if (item.r1 != 8'd0) begin
            lfail = 1'b1;
          end else begin
            st_next.phase  = PH_CMD16;
            has_result     = 1'b1;
            res.cmd_index  = CMD_SET_BLKLEN;
            res.cmd_arg    = ARG_BLKLEN;
            res.high_speed = 1'b1;
          end
        end
        PH_CMD16: begin
          fin = 1'b1;
          if (item.r1 == 8'd0) fin_type = st.type_found;
        end
        default: ;
      endcase
    end

    if (lstart) begin
      st_next.loop_command = lcmd;
      if (cfg.retry_limit == 16'd0) begin
        fin = 1'b1;
      end else begin
        st_next.retries_left = cfg.retry_limit;
        st_next.phase        = lphase;
        has_result           = 1'b1;
        res.cmd_index        = lcmd;
        res.cmd_arg          = (lphase == PH_V2LOOP) ? ARG_HCS : 32'd0;
        res.app_cmd          = (lcmd == CMD_APP_OP);
        res.high_speed       = 1'b1;
      end
    end

    if (lfail) begin
      st_next.retries_left = dec;
      if (dec == 16'd0) begin
        fin = 1'b1;
      end else begin
        has_result     = 1'b1;
        res.cmd_index  = st.loop_command;
        res.cmd_arg    = (st.phase == PH_V2LOOP) ? ARG_HCS : 32'd0;
        res.app_cmd    = (st.loop_command == CMD_APP_OP);
        res.wait_units = cfg.retry_wait;
        res.high_speed = 1'b1;
      end
    end

    if (fin) begin
      st_next.type_found         = fin_type;
      st_next.disk_uninitialized = (fin_type == CT_NONE);
      st_next.phase              = PH_IDLE;
      has_result                 = 1'b1;
      res                        = '0;
      res.done_res               = 1'b1;
      res.card_type              = fin_type;
      res.not_ready              = (fin_type == CT_NONE);
    end
  end

endmodule

// ===== rtl/sd_spi_card_init_sequencer_unit.sv =====
// Top level of the SD card SPI-mode start-up sequencer.
// Depends on sdi_pkg, sdi_cfg and sdi_step.
//
// Usage:
//   Slave stream: s_tuser is the item kind (0 start, 1 card response);
//   s_tdata carries the drive number, the R1 byte and the four trailing bytes.
//   Master stream: one word per item that produces a result; m_tuser is 1 for
//   the final word (card type and not-ready flag), 0 for a command word.
//   A response that arrives while no sequence runs produces no word.
//   An accepted item passes through the input register, then the result
//   register, to the master side. Throughput: one item per cycle while the
//   receiver does not stall; the sequencer state is updated in one pass of
//   the step logic as the item moves from the input register into the result
//   register. When the receiver stalls, the result register holds its word
//   and the input register holds one more item; s_tready drops only while
//   both are full.
//   Reset (rst, synchronous) empties both registers, returns the sequencer to
//   idle with the disk marked uninitialized and loads the register defaults
//   (retry limit 1000, retry wait 20, power-up wait 200).
//   Registers: 0x0 retry limit, 0x4 retry wait, 0x8 power-up wait; write only
//   while the block is idle.
module sd_spi_card_init_sequencer_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [47:0]               s_tdata,  // drive[7:0], r1[15:8], trailing[47:16]
  input  logic                      s_tuser,  // kind
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // cmd_index[5:0], cmd_arg[37:6], app_cmd[38], wait_units[54:39],
  // dummy_clocks[55], high_speed[56], read_trailing[57], card_type[61:58],
  // not_ready[62], zero[63]
  output logic [63:0]               m_tdata,
  output logic                      m_tuser,  // done_res
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sdi_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import sdi_pkg::*;

  cfg_t       cfg;
  seq_state_t st;
  seq_state_t st_next;
  item_t      in_item;
  logic       in_valid;
  result_t    res;
  result_t    res_next;
  logic       has_result;
  logic       advance;

  sdi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdi_step u_step (
    .st         (st),
    .cfg        (cfg),
    .item       (in_item),
    .st_next    (st_next),
    .has_result (has_result),
    .res        (res_next)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.kind     <= s_tuser;
      in_item.drive    <= s_tdata[7:0];
      in_item.r1       <= s_tdata[15:8];
      in_item.trailing <= s_tdata[47:16];
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase              <= PH_IDLE;
      st.retries_left       <= 16'd0;
      st.type_found         <= CT_NONE;
      st.loop_command       <= 6'd0;
      st.disk_uninitialized <= 1'b1;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res <= res_next;
  end

  assign m_tuser = res.done_res;
  assign m_tdata = {1'b0, res.not_ready, res.card_type, res.read_trailing,
                    res.high_speed, res.dummy_clocks, res.wait_units,
                    res.app_cmd, res.cmd_arg, res.cmd_index};

  // A final word reports not-ready exactly when no card type was found
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[62] == (m_tdata[61:58] == CT_NONE)))
    else $error("final word not-ready flag disagrees with card type");

  // A command word carries no card type and no not-ready flag
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[61:58] == CT_NONE) && !m_tdata[62])
    else $error("command word carries final-word fields");

  // A leave-idle loop always has attempts left
  assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_V2LOOP || st.phase == PH_V1LOOP) |-> st.retries_left != 16'd0)
    else $error("retry loop active with no attempts left");

  // Input side stalls only behind a held result word
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a held result");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the SD card SPI-mode start-up sequencer.
// Depends on sdi_pkg, sdi_cfg, sdi_step and sd_spi_card_init_sequencer_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdi_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // drive[7:0], r1[15:8], trailing[47:16]
  logic        s_tuser = 1'b0;  // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // cmd_index[5:0], cmd_arg[37:6], app_cmd[38], wait_units[54:39],
  // dummy_clocks[55], high_speed[56], read_trailing[57], card_type[61:58],
  // not_ready[62], zero[63]
  logic [63:0] m_tdata;
  logic        m_tuser;  // done_res
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sd_spi_card_init_sequencer_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the sequencer and its registers
  logic [15:0] lim = RETRY_LIMIT_RST;
  logic [15:0] rwait = RETRY_WAIT_RST;
  logic [15:0] puw = POWER_UP_WAIT_RST;
  phase_t      ph = PH_IDLE;
  logic [15:0] retries = '0;
  logic [3:0]  ty = CT_NONE;
  logic [5:0]  loop_cmd = '0;
  logic        uninit = 1'b1;

  item_t   pending[$];
  result_t expected_words[$];
  int      errors = 0;
  int      accepted_items = 0;
  int      queued = 0;

  task automatic report(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  function automatic result_t cmd_word(input logic [5:0] idx, input logic [31:0] arg,
                                       input logic app, input logic [15:0] w,
                                       input logic dummy, input logic hs, input logic trail);
    result_t r;
    r = '0;
    r.cmd_index = idx;
    r.cmd_arg = arg;
    r.app_cmd = app;
    r.wait_units = w;
    r.dummy_clocks = dummy;
    r.high_speed = hs;
    r.read_trailing = trail;
    return r;
  endfunction

  function automatic result_t final_word(input logic [3:0] t);
    result_t r;
    r = '0;
    r.done_res = 1'b1;
    r.card_type = t;
    r.not_ready = (t == CT_NONE);
    return r;
  endfunction

  function automatic result_t end_seq(input logic [3:0] t);
    ty = t;
    uninit = (t == CT_NONE);
    ph = PH_IDLE;
    return final_word(t);
  endfunction

  function automatic result_t loop_word(input logic [15:0] w);
    return cmd_word(loop_cmd, (ph == PH_V2LOOP) ? ARG_HCS : 32'd0,
                    loop_cmd == CMD_APP_OP, w, 1'b0, 1'b1, 1'b0);
  endfunction

  function automatic result_t loop_enter(input phase_t p);
    if (lim == 0) return end_seq(CT_NONE);
    retries = lim;
    ph = p;
    return loop_word(16'd0);
  endfunction

  function automatic result_t loop_retry();
    if (retries > 0) retries--;
    if (retries == 0) return end_seq(CT_NONE);
    return loop_word(rwait);
  endfunction

  // Advance the shadow sequencer by one item; return 1 when a result follows
  function automatic bit step_card(input logic kind, input logic [7:0] drive,
                                   input logic [7:0] r1, input logic [31:0] tr,
                                   output result_t r);
    r = '0;
    if (kind == KIND_START) begin
      if (drive != 8'd0) begin
        ph = PH_IDLE;
        r = final_word(CT_NONE);
        return 1'b1;
      end
      ph = PH_CMD0;
      ty = CT_NONE;
      retries = '0;
      r = cmd_word(CMD_GO_IDLE, 32'd0, 1'b0, puw, 1'b1, 1'b0, 1'b0);
      return 1'b1;
    end
    case (ph)
      PH_CMD0: begin
        if (r1 != R1_IDLE) r = end_seq(CT_NONE);
        else begin
          ph = PH_CMD8;
          r = cmd_word(CMD_IF_COND, ARG_IF_COND, 1'b0, 16'd0, 1'b0, 1'b1, 1'b1);
        end
      end
      PH_CMD8: begin
        if (r1 == R1_IDLE) begin
          if (tr[15:8] != R7_VHS || tr[7:0] != R7_PATTERN) r = end_seq(CT_NONE);
          else begin
            loop_cmd = CMD_APP_OP;
            r = loop_enter(PH_V2LOOP);
          end
        end else begin
          ph = PH_PROBE;
          r = cmd_word(CMD_APP_OP, 32'd0, 1'b1, 16'd0, 1'b0, 1'b1, 1'b0);
        end
      end
      PH_V2LOOP: begin
        if (r1 != 8'd0) r = loop_retry();
        else begin
          ph = PH_CMD58;
          r = cmd_word(CMD_READ_OCR, 32'd0, 1'b0, 16'd0, 1'b0, 1'b1, 1'b1);
        end
      end
      PH_CMD58: begin
        if (r1 != 8'd0) r = end_seq(CT_NONE);
        else r = end_seq(tr[30] ? (CT_SD2 | CT_BLKADDR) : CT_SD2);
      end
      PH_PROBE: begin
        if (r1 <= 8'd1) begin
          ty = CT_SD1;
          loop_cmd = CMD_APP_OP;
        end else begin
          ty = CT_MMC;
          loop_cmd = CMD_SEND_OP;
        end
        r = loop_enter(PH_V1LOOP);
      end
      PH_V1LOOP: begin
        if (r1 != 8'd0) r = loop_retry();
        else begin
          ph = PH_CMD16;
          r = cmd_word(CMD_SET_BLKLEN, ARG_BLKLEN, 1'b0, 16'd0, 1'b0, 1'b1, 1'b0);
        end
      end
      PH_CMD16: begin
        if (r1 != 8'd0) r = end_seq(CT_NONE);
        else r = end_seq(ty);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Sender: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        it = pending.pop_front();
        s_tdata <= {it.trailing, it.r1, it.drive};
        s_tuser <= it.kind;
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall rate changes each time a 6-bit counter wraps, plus one long hold-off
  int   hold_left = 0;
  bit   held = 1'b0;
  int   stall_pct = 0;
  logic [5:0] cyc = '0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      cyc <= cyc + 1'b1;
      if (cyc == 6'd0) stall_pct <= 25 * $urandom_range(0, 3);
      if (!held && accepted_items >= 300) begin
        held <= 1'b1;
        hold_left <= 400;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Check words leaving the block, then predict for the word entering it
  always @(posedge clk) begin
    result_t e;
    result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word %h done %b", m_tdata, m_tuser));
      end else begin
        e = expected_words.pop_front();
        check_field("cmd_index", 32'(m_tdata[5:0]), 32'(e.cmd_index));
        check_field("cmd_arg", m_tdata[37:6], e.cmd_arg);
        check_field("app_cmd", 32'(m_tdata[38]), 32'(e.app_cmd));
        check_field("wait_units", 32'(m_tdata[54:39]), 32'(e.wait_units));
        check_field("dummy_clocks", 32'(m_tdata[55]), 32'(e.dummy_clocks));
        check_field("high_speed", 32'(m_tdata[56]), 32'(e.high_speed));
        check_field("read_trailing", 32'(m_tdata[57]), 32'(e.read_trailing));
        check_field("card_type", 32'(m_tdata[61:58]), 32'(e.card_type));
        check_field("not_ready", 32'(m_tdata[62]), 32'(e.not_ready));
        check_field("done_res", 32'(m_tuser), 32'(e.done_res));
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      accepted_items <= accepted_items + 1;
      if (step_card(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[47:16], w))
        expected_words.push_back(w);
    end
  end

  task automatic queue_item(input logic kind, input logic [7:0] drive,
                            input logic [7:0] r1, input logic [31:0] tr);
    item_t it;
    it.kind = kind;
    it.drive = drive;
    it.r1 = r1;
    it.trailing = tr;
    pending.push_back(it);
    queued++;
  endtask

  task automatic reply(input logic [7:0] r1, input logic [31:0] tr);
    queue_item(KIND_RESPONSE, 8'($urandom), r1, tr);
  endtask

  // Hold until every word is in and out, then let the pipeline drain
  task automatic wait_idle();
    while (pending.size() > 0 || s_tvalid || expected_words.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_RETRY_LIMIT: lim = val;
      REG_RETRY_WAIT: rwait = val;
      REG_POWER_UP_WAIT: puw = val;
      default: ;
    endcase
    // read back
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {16'h0000, val})
      report($sformatf("register %0d reads %h want %h", idx, prdata, val));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // One start-up attempt, mostly well formed, with random content
  task automatic add_sequence();
    int route;
    int fails;
    logic [31:0] tr;
    logic [7:0] r1;
    route = $urandom_range(0, 9);
    if (route == 9) begin
      repeat ($urandom_range(1, 4))
        queue_item($urandom_range(0, 3) != 0, 8'($urandom), 8'($urandom), $urandom);
      return;
    end
    if ($urandom_range(0, 15) == 0) begin
      queue_item(KIND_START, 8'($urandom_range(1, 255)), 8'($urandom), $urandom);
      return;
    end
    queue_item(KIND_START, 8'd0, 8'($urandom), $urandom);
    reply(($urandom_range(0, 15) == 0) ? 8'($urandom) : R1_IDLE, $urandom);
    if (route < 4) begin
      tr = $urandom;
      if ($urandom_range(0, 15) != 0) tr[15:0] = {R7_VHS, R7_PATTERN};
      reply(R1_IDLE, tr);
    end else begin
      r1 = 8'($urandom);
      if (r1 == R1_IDLE) r1 = 8'h05;
      reply(r1, $urandom);
      reply((route < 7) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 255)), $urandom);
    end
    fails = (lim <= 8) ? $urandom_range(0, lim) : $urandom_range(0, 5);
    repeat (fails) reply(($urandom_range(0, 1) != 0) ? R1_IDLE : 8'($urandom_range(1, 255)),
                         $urandom);
    if ($urandom_range(0, 9) == 0) return;
    reply(($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'h00, $urandom);
    reply(($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'h00, $urandom);
  endtask

  initial begin
    logic [15:0] sets [5][3];
    sets = '{'{16'd3, 16'd0, 16'd0}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
             '{16'd1, 16'h5A5A, 16'hA5A5}, '{16'd5, 16'd0, 16'd0},
             '{RETRY_LIMIT_RST, RETRY_WAIT_RST, POWER_UP_WAIT_RST}};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // response with no sequence running, then a drive that does not exist
    reply(8'h00, 32'h0);
    queue_item(KIND_START, 8'hFF, 8'h00, 32'h0);
    // SDv2 with block addressing, restarted once mid-sequence, one retry
    queue_item(KIND_START, 8'h00, 8'h00, 32'h0);
    reply(R1_IDLE, 32'h0);
    queue_item(KIND_START, 8'h00, 8'hFF, 32'hFFFF_FFFF);
    reply(R1_IDLE, 32'h0);
    reply(R1_IDLE, 32'h0000_01AA);
    reply(R1_IDLE, 32'h0);
    reply(8'h00, 32'h0);
    reply(8'h00, 32'hC0FF_8000);
    // SDv1
    queue_item(KIND_START, 8'h00, 8'h00, 32'h0);
    reply(R1_IDLE, 32'h0);
    reply(8'h05, 32'h0);
    reply(8'h00, 32'h0);
    reply(8'h00, 32'h0);
    reply(8'h00, 32'h0);
    // MMC, block length refused
    queue_item(KIND_START, 8'h00, 8'h00, 32'h0);
    reply(R1_IDLE, 32'h0);
    reply(8'h05, 32'h0);
    reply(8'h04, 32'h0);
    reply(8'h00, 32'h0);
    reply(8'h04, 32'h0);
    // card never reaches idle
    queue_item(KIND_START, 8'h00, 8'h00, 32'h0);
    reply(8'h00, 32'h0);
    wait_idle();

    // zero retry limit: both leave-idle loops give up at once
    set_reg(REG_RETRY_LIMIT, 16'd0);
    queue_item(KIND_START, 8'h00, 8'h00, 32'h0);
    reply(R1_IDLE, 32'h0);
    reply(R1_IDLE, 32'h0000_01AA);
    queue_item(KIND_START, 8'h00, 8'h00, 32'h0);
    reply(R1_IDLE, 32'h0);
    reply(8'hFF, 32'h0);
    reply(8'h00, 32'h0);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      if (p == 3) begin
        sets[p][0] = 16'($urandom_range(2, 8));
        sets[p][1] = 16'($urandom);
        sets[p][2] = 16'($urandom);
      end
      set_reg(REG_RETRY_LIMIT, sets[p][0]);
      set_reg(REG_RETRY_WAIT, sets[p][1]);
      set_reg(REG_POWER_UP_WAIT, sets[p][2]);
      queued = 0;
      while (queued < 110) add_sequence();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule
